// ===== sv/sgat_pkg.sv =====
// ----------------------------------------------------------------------------
// sgat_pkg: shared types and constants
// Operation and status codes, plus the control groups that travel between
// the translator top level and its chain of segment cells.
// ----------------------------------------------------------------------------
package sgat_pkg;

   localparam int FIELD_BITS = 48;
   localparam int OP_BITS    = 2;
   localparam int STAT_BITS  = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_FWD    = 2'd2,
      OP_REV    = 2'd3
   } op_type;

   typedef enum logic [STAT_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // walk token traveling along the cells
   typedef struct packed {
      logic valid;
      logic reverse;
   } tok_ctrl_type;

   // result produced by a cell
   typedef struct packed {
      logic       valid;
      logic       last;
      status_type status;
   } emit_ctrl_type;

endpackage

// ===== sv/sgat_if.sv =====
// ----------------------------------------------------------------------------
// sgat interfaces: request and response channels
// Valid/ready channels carrying one translator request or one response.
// ----------------------------------------------------------------------------
interface sgat_req_if;
   logic                             valid;
   logic                             ready;
   logic [sgat_pkg::OP_BITS-1:0]     operation;
   logic [sgat_pkg::FIELD_BITS-1:0]  offset;
   logic [sgat_pkg::FIELD_BITS-1:0]  length;

   modport source (output valid, operation, offset, length, input ready);
   modport sink   (input valid, operation, offset, length, output ready);
endinterface

interface sgat_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sgat_pkg::STAT_BITS-1:0]   status;
   logic [sgat_pkg::FIELD_BITS-1:0]  span_offset;
   logic [sgat_pkg::FIELD_BITS-1:0]  span_length;
   logic                             last;

   modport source (output valid, status, span_offset, span_length, last, input ready);
   modport sink   (input valid, status, span_offset, span_length, last, output ready);
endinterface

// ===== sv/sgat_cell.sv =====
// ----------------------------------------------------------------------------
// sgat_cell: one segment slot of the translation chain
// Holds one segment and a token register; checks the token against its
// segment, emits a span or lookup result and hands the token onward.
// ----------------------------------------------------------------------------
module sgat_cell #(
   parameter int OFFSET_BITS = 48,
   parameter int COUNT_W     = 5,
   parameter int INDEX       = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stall,
   input  logic                        wr_en,
   input  logic [OFFSET_BITS-1:0]      wr_physical,
   input  logic [OFFSET_BITS-1:0]      wr_length,
   input  logic [OFFSET_BITS-1:0]      wr_logical,
   input  logic [COUNT_W-1:0]          count,
   input  sgat_pkg::tok_ctrl_type      tok_in,
   input  logic [OFFSET_BITS-1:0]      pos_in,
   input  logic [OFFSET_BITS-1:0]      rem_in,
   output sgat_pkg::tok_ctrl_type      tok_out,
   output logic [OFFSET_BITS-1:0]      pos_out,
   output logic [OFFSET_BITS-1:0]      rem_out,
   output sgat_pkg::emit_ctrl_type     emit,
   output logic [OFFSET_BITS-1:0]      emit_offset,
   output logic [OFFSET_BITS-1:0]      emit_length,
   output logic                        active
);

   localparam int W = OFFSET_BITS;
   localparam logic [COUNT_W-1:0] SLOT = COUNT_W'(INDEX);

   logic [W-1:0]           phys_ff;
   logic [W-1:0]           len_ff;
   logic [W-1:0]           logi_ff;
   sgat_pkg::tok_ctrl_type tok_ff;
   logic [W-1:0]           pos_ff;
   logic [W-1:0]           rem_ff;

   logic         live;
   logic [W:0]   d_start;
   logic [W:0]   d_phys;
   logic         ge_start;
   logic [W-1:0] in_seg;
   logic [W-1:0] gap;
   logic [W-1:0] avail;
   logic [W-1:0] take;
   logic         past;
   logic         before_seg;
   logic         hit;

   always_ff @(posedge clock) begin
      if (wr_en && count == SLOT) begin
         phys_ff <= wr_physical;
         len_ff  <= wr_length;
         logi_ff <= wr_logical;
      end
      if (!stall) begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
      end
      if (reset) begin
         tok_ff <= '0;
      end else if (!stall) begin
         tok_ff <= tok_in;
      end
   end

   assign live     = count > SLOT;
   assign d_start  = {1'b0, pos_ff} - {1'b0, logi_ff};
   assign d_phys   = {1'b0, pos_ff} - {1'b0, phys_ff};
   assign ge_start = !d_start[W];
   assign gap      = logi_ff - pos_ff;
   assign past     = ge_start && (d_start[W-1:0] >= len_ff);
   assign before_seg = !ge_start && (rem_ff <= gap);
   assign in_seg   = ge_start ? d_start[W-1:0] : '0;
   assign avail    = len_ff - in_seg;
   assign take     = (rem_ff < avail) ? rem_ff : avail;
   assign hit      = !d_phys[W] && (d_phys[W-1:0] < len_ff);
   assign active   = tok_ff.valid;

   always_comb begin
      emit        = '0;
      emit_offset = '0;
      emit_length = '0;
      tok_out     = '0;
      pos_out     = pos_ff;
      rem_out     = rem_ff;
      if (tok_ff.valid) begin
         if (!live) begin
            // walked past the filled part of the table
            emit.valid  = 1'b1;
            emit.last   = 1'b1;
            emit.status = tok_ff.reverse ? sgat_pkg::ST_NOTFOUND : sgat_pkg::ST_RANGE;
         end else if (tok_ff.reverse) begin
            if (hit) begin
               emit.valid  = 1'b1;
               emit.last   = 1'b1;
               emit.status = sgat_pkg::ST_OK;
               emit_offset = logi_ff + d_phys[W-1:0];
            end else begin
               tok_out = tok_ff;
            end
         end else if (past) begin
            tok_out = tok_ff;
         end else if (before_seg) begin
            emit.valid  = 1'b1;
            emit.last   = 1'b1;
            emit.status = sgat_pkg::ST_RANGE;
         end else begin
            emit.valid    = 1'b1;
            emit.last     = (take == rem_ff);
            emit.status   = sgat_pkg::ST_OK;
            emit_offset   = phys_ff + in_seg;
            emit_length   = take;
            tok_out.valid = (take != rem_ff);
            pos_out       = pos_ff + take;
            rem_out       = rem_ff - take;
         end
      end
   end

endmodule

// ===== sv/segmented_stream_address_translator.sv =====
// ----------------------------------------------------------------------------
// segmented_stream_address_translator: segment table address translation
// Clear, append, logical-to-physical and physical-to-logical lookups over
// an ordered segment table held in a chain of cells.
// ----------------------------------------------------------------------------
// clear, append, zero-length forward lookups and rejected ranges answer
//   in the cycle after acceptance; other lookups walk the cell chain one
//   cell per cycle unless the response output stalls
// throughput: one transaction at a time; a new one is taken once the walk ends
// reset clears the segment count, logical total, walk tokens and response
//   valid flag; segment contents are left as they are
module segmented_stream_address_translator #(
   parameter int MAX_SEGMENTS = 16,
   parameter int OFFSET_BITS  = 48
) (
   input  logic clock,
   input  logic reset,
   sgat_req_if.sink   req_bus,
   sgat_rsp_if.source rsp_bus
);

   localparam int W       = OFFSET_BITS;
   localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_SEGMENTS);
   localparam int FB      = sgat_pkg::FIELD_BITS;

   logic [COUNT_W-1:0]       count_ff;
   logic [W-1:0]             total_ff;
   logic                     busy_ff;
   sgat_pkg::tok_ctrl_type   tail_ff;
   logic                     rsp_valid_ff;
   sgat_pkg::status_type     rsp_status_ff;
   logic [FB-1:0]            rsp_offset_ff;
   logic [FB-1:0]            rsp_length_ff;
   logic                     rsp_last_ff;

   sgat_pkg::op_type         op;
   logic [W-1:0]             off_v;
   logic [W-1:0]             len_v;
   logic [W:0]               sum;
   logic [W-1:0]             room;
   logic                     accept;
   logic                     can_load;
   logic                     launch;
   logic                     wr_en;
   sgat_pkg::status_type     dir_status;
   logic [W-1:0]             dir_offset;
   logic [W-1:0]             dir_length;

   sgat_pkg::tok_ctrl_type   tok_chain [0:MAX_SEGMENTS];
   logic [W-1:0]             pos_chain [0:MAX_SEGMENTS];
   logic [W-1:0]             rem_chain [0:MAX_SEGMENTS];
   sgat_pkg::emit_ctrl_type  cell_emit [0:MAX_SEGMENTS-1];
   logic [W-1:0]             cell_off  [0:MAX_SEGMENTS-1];
   logic [W-1:0]             cell_len  [0:MAX_SEGMENTS-1];
   logic [MAX_SEGMENTS-1:0]  cell_active;

   sgat_pkg::emit_ctrl_type  walk_emit;
   logic [W-1:0]             walk_offset;
   logic [W-1:0]             walk_length;
   logic                     stall;

   assign op       = sgat_pkg::op_type'(req_bus.operation);
   assign off_v    = W'(req_bus.offset);
   assign len_v    = W'(req_bus.length);
   assign sum      = {1'b0, total_ff} + {1'b0, len_v};
   assign room     = total_ff - off_v;
   assign can_load = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !busy_ff && can_load;
   assign accept   = req_bus.valid && req_bus.ready;

   // operations answered straight from the count and total, and the walk launch
   always_comb begin
      dir_status = sgat_pkg::ST_OK;
      dir_offset = '0;
      dir_length = '0;
      launch     = 1'b0;
      wr_en      = 1'b0;
      case (op)
         sgat_pkg::OP_CLEAR: begin
            dir_status = sgat_pkg::ST_OK;
         end
         sgat_pkg::OP_APPEND: begin
            if (count_ff >= MAX_COUNT) begin
               dir_status = sgat_pkg::ST_FULL;
            end else if (sum[W]) begin
               dir_status = sgat_pkg::ST_RANGE;
            end else begin
               dir_offset = total_ff;
               dir_length = len_v;
               wr_en      = accept;
            end
         end
         sgat_pkg::OP_FWD: begin
            if (off_v > total_ff) begin
               dir_status = sgat_pkg::ST_RANGE;
            end else if (len_v == '0) begin
               dir_status = sgat_pkg::ST_OK;
            end else if (len_v > room) begin
               dir_status = sgat_pkg::ST_RANGE;
            end else begin
               launch = 1'b1;
            end
         end
         sgat_pkg::OP_REV: begin
            launch = 1'b1;
         end
         default: begin
            dir_status = sgat_pkg::ST_OK;
         end
      endcase
   end

   assign tok_chain[0].valid   = accept && launch;
   assign tok_chain[0].reverse = (op == sgat_pkg::OP_REV);
   assign pos_chain[0]         = off_v;
   assign rem_chain[0]         = len_v;

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      sgat_cell #(
         .OFFSET_BITS (OFFSET_BITS),
         .COUNT_W     (COUNT_W),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .stall       (stall),
         .wr_en       (wr_en),
         .wr_physical (off_v),
         .wr_length   (len_v),
         .wr_logical  (total_ff),
         .count       (count_ff),
         .tok_in      (tok_chain[i]),
         .pos_in      (pos_chain[i]),
         .rem_in      (rem_chain[i]),
         .tok_out     (tok_chain[i+1]),
         .pos_out     (pos_chain[i+1]),
         .rem_out     (rem_chain[i+1]),
         .emit        (cell_emit[i]),
         .emit_offset (cell_off[i]),
         .emit_length (cell_len[i]),
         .active      (cell_active[i])
      );
   end

   // at most one cell holds the token, so an or-merge picks its result
   always_comb begin
      walk_emit   = '0;
      walk_offset = '0;
      walk_length = '0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
         walk_emit   = sgat_pkg::emit_ctrl_type'(walk_emit | cell_emit[i]);
         walk_offset = walk_offset | cell_off[i];
         walk_length = walk_length | cell_len[i];
      end
      if (tail_ff.valid) begin
         walk_emit.valid  = 1'b1;
         walk_emit.last   = 1'b1;
         walk_emit.status = tail_ff.reverse ? sgat_pkg::ST_NOTFOUND : sgat_pkg::ST_RANGE;
      end
   end

   assign stall = walk_emit.valid && !can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         busy_ff      <= 1'b0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!stall) begin
            tail_ff <= tok_chain[MAX_SEGMENTS];
         end
         if (accept && op == sgat_pkg::OP_CLEAR) begin
            count_ff <= '0;
            total_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + COUNT_W'(1);
            total_ff <= sum[W-1:0];
         end
         if (accept && launch) begin
            busy_ff <= 1'b1;
         end else if (walk_emit.valid && walk_emit.last && can_load) begin
            busy_ff <= 1'b0;
         end
         if (can_load) begin
            rsp_valid_ff <= (accept && !launch) || walk_emit.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (can_load) begin
         if (accept && !launch) begin
            rsp_status_ff <= dir_status;
            rsp_offset_ff <= FB'(dir_offset);
            rsp_length_ff <= FB'(dir_length);
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_status_ff <= walk_emit.status;
            rsp_offset_ff <= FB'(walk_offset);
            rsp_length_ff <= FB'(walk_length);
            rsp_last_ff   <= walk_emit.last;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.span_offset = rsp_offset_ff;
   assign rsp_bus.span_length = rsp_length_ff;
   assign rsp_bus.last        = rsp_last_ff;

   a_single_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_active, tail_ff.valid}))
      else $error("more than one walk token in the chain");

   a_emit_busy : assert property (@(posedge clock) disable iff (reset)
      walk_emit.valid |-> busy_ff)
      else $error("chain result while no walk is in progress");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("segment count beyond table size");

   a_walk_done : assert property (@(posedge clock) disable iff (reset)
      (walk_emit.valid && walk_emit.last && can_load) |=> !busy_ff)
      else $error("walk still busy after its final result");

endmodule
